FILE: src/rst_pkg.sv
package rst_pkg;

    localparam int MAX_DEPTH = 8;
    localparam int LEN_BITS  = 32;
    localparam int LVL_W     = $clog2(MAX_DEPTH + 1);
    localparam int IDX_W     = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DOLAR = 8'h24;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [3:0] EV_SIMPLE  = 4'd0;
    localparam logic [3:0] EV_ERRSTR  = 4'd1;
    localparam logic [3:0] EV_BULK    = 4'd2;
    localparam logic [3:0] EV_PAYLOAD = 4'd3;
    localparam logic [3:0] EV_END     = 4'd4;
    localparam logic [3:0] EV_INT     = 4'd5;
    localparam logic [3:0] EV_NULL    = 4'd6;
    localparam logic [3:0] EV_ARRAY   = 4'd7;
    localparam logic [3:0] EV_FAULT   = 4'd8;

    localparam logic [2:0] ERR_NONE   = 3'd0;
    localparam logic [2:0] ERR_PREFIX = 3'd1;
    localparam logic [2:0] ERR_INT    = 3'd2;
    localparam logic [2:0] ERR_LEN    = 3'd3;
    localparam logic [2:0] ERR_BULK   = 3'd4;
    localparam logic [2:0] ERR_COUNT  = 3'd5;
    localparam logic [2:0] ERR_DEEP   = 3'd6;
    localparam logic [2:0] ERR_BIG    = 3'd7;

    localparam logic [2:0] LP_SIMPLE  = 3'd0;
    localparam logic [2:0] LP_ERROR   = 3'd1;
    localparam logic [2:0] LP_INT     = 3'd2;
    localparam logic [2:0] LP_BULKLEN = 3'd3;
    localparam logic [2:0] LP_COUNT   = 3'd4;

    typedef enum logic [4:0] {
        PH_PREFIX  = 5'b00001,
        PH_LINE    = 5'b00010,
        PH_BULK    = 5'b00100,
        PH_BULK_CR = 5'b01000,
        PH_BULK_LF = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [3:0]  event_res;
        logic [7:0]  payload_byte;
        logic [63:0] number;
        logic [3:0]  nest_level;
        logic        message_done;
        logic [2:0]  error_code;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    r0;
        result_t    r1;
    } push_t;

endpackage

FILE: src/resp_stream_tokenizer.sv
// Channel   Direction  Handshake              Payload
// in        to block   in_valid / in_stall    action, stream_byte
// out       from block out_valid / out_stall  event_res, payload_byte, number,
//                                             nest_level, message_done, error_code, last
//
// One word is taken per cycle while in_stall is low; its state update and events are
// formed in the cycle it is accepted and land in a four-entry result queue.
// A word yields zero, one or two events; sustained rate is one word per cycle
// while the queue drains at least as fast as words add events.
// in_stall rises while fewer than two queue entries are free (a stall on out).
// Reset (async, rst_n low) empties the queue and returns the parser to
// waiting for a type prefix; a clear word does the same for the parser alone.
module resp_stream_tokenizer (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               action,
    input  logic [7:0]         stream_byte,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [3:0]         event_res,
    output logic [7:0]         payload_byte,
    output logic signed [63:0] number,
    output logic [3:0]         nest_level,
    output logic               message_done,
    output logic [2:0]         error_code,
    output logic               last
);

    rst_pkg::push_t   push;
    rst_pkg::result_t head;
    logic             room;
    logic             go;

    // Accept a word only with room for its worst-case two events.
    assign in_stall = !room;
    assign go       = in_valid && room;

    rst_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .go          (go),
        .action      (action),
        .stream_byte (stream_byte),
        .push        (push)
    );

    rst_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .pop        (out_valid && !out_stall),
        .room       (room),
        .head_valid (out_valid),
        .head       (head)
    );

    assign event_res    = head.event_res;
    assign payload_byte = head.payload_byte;
    assign number       = $signed(head.number);
    assign nest_level   = head.nest_level;
    assign message_done = head.message_done;
    assign error_code   = head.error_code;
    assign last         = head.last;

endmodule

FILE: src/rst_core.sv
module rst_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                go,
    input  logic                action,
    input  logic [7:0]          stream_byte,
    output rst_pkg::push_t      push
);

    typedef struct packed {
        logic [63:0] accum;
        logic        neg;
        logic        digit;
        logic        past;
        logic        inval;
    } int_st_t;

    localparam int LW = rst_pkg::LEN_BITS;
    localparam int DW = rst_pkg::LVL_W;
    localparam int IW = rst_pkg::IDX_W;
    localparam int MD = rst_pkg::MAX_DEPTH;

    rst_pkg::phase_t phase_reg, phase_next;
    logic [2:0]      purpose_reg, purpose_next;
    logic            held_reg, held_next;
    int_st_t         ist_reg, ist_next, ist_cr;
    logic [LW-1:0]   bulk_reg, bulk_next;
    logic [DW-1:0]   level_reg, level_next;
    logic            halted_reg, halted_next;

    logic [LW-1:0]   stack_reg [MD];
    logic [MD-1:0]   one_reg;
    logic            stk_we;
    logic [IW-1:0]   stk_idx;
    logic [LW-1:0]   stk_wdata;
    logic            one_wdata;

    logic            fv_found;
    logic [IW-1:0]   fv_idx;
    logic [DW-1:0]   fv_level;
    logic [LW-1:0]   fv_val;
    logic            is_str;
    logic            too_big;
    logic [63:0]     int_val;

    function automatic logic is_space(logic [7:0] c);
        return (c == rst_pkg::CH_SPACE) || (c >= rst_pkg::CH_TAB && c <= rst_pkg::CH_CR);
    endfunction

    function automatic int_st_t int_char(int_st_t s, logic [7:0] c);
        int_st_t     r;
        logic [67:0] prod;
        logic [67:0] lim;
        r    = s;
        prod = {1'b0, s.accum, 3'b000} + {3'b000, s.accum, 1'b0}
             + {60'd0, c - rst_pkg::CH_ZERO};
        lim  = {5'd0, 63'h7FFF_FFFF_FFFF_FFFF} + {67'd0, s.neg};
        if (!s.inval) begin
            if (s.past || !is_space(c)) begin
                r.past = 1'b1;
                if (!s.past && (c == rst_pkg::CH_PLUS || c == rst_pkg::CH_MINUS)) begin
                    r.neg = (c == rst_pkg::CH_MINUS);
                end
                else if (c >= rst_pkg::CH_ZERO && c <= rst_pkg::CH_NINE) begin
                    if (prod > lim) begin
                        r.inval = 1'b1;
                    end
                    else begin
                        r.accum = prod[63:0];
                        r.digit = 1'b1;
                    end
                end
                else begin
                    r.inval = 1'b1;
                end
            end
        end
        return r;
    endfunction

    function automatic rst_pkg::result_t mk(logic [3:0] ev, logic [7:0] pb, logic [63:0] num,
                                            logic [DW-1:0] lvl, logic done, logic [2:0] err);
        rst_pkg::result_t r;
        r.event_res    = ev;
        r.payload_byte = pb;
        r.number       = num;
        r.nest_level   = 4'(lvl);
        r.message_done = done;
        r.error_code   = err;
        r.last         = 1'b0;
        return r;
    endfunction

    // Pop finished arrays: the highest level below the top whose count is not one stays.
    always_comb
    begin
        fv_found = 1'b0;
        fv_idx   = '0;
        for (int k = 0; k < MD; k++)
        begin
            if (DW'(k) < level_reg && !one_reg[k])
            begin
                fv_found = 1'b1;
                fv_idx   = IW'(k);
            end
        end
        fv_level = fv_found ? DW'(fv_idx) + DW'(1) : '0;
        fv_val   = stack_reg[fv_idx];
    end

    assign is_str  = (purpose_reg == rst_pkg::LP_SIMPLE) || (purpose_reg == rst_pkg::LP_ERROR);
    assign too_big = (ist_reg.accum >> LW) != 64'd0;
    assign int_val = ist_reg.neg ? (64'd0 - ist_reg.accum) : ist_reg.accum;

    always_comb
    begin
        ist_cr = ist_reg;
        if (!ist_reg.inval && ist_reg.past)
        begin
            ist_cr.inval = 1'b1;
        end
    end

    always_comb
    begin
        phase_next   = phase_reg;
        purpose_next = purpose_reg;
        held_next    = held_reg;
        ist_next     = ist_reg;
        bulk_next    = bulk_reg;
        level_next   = level_reg;
        halted_next  = halted_reg;
        stk_we       = 1'b0;
        stk_idx      = fv_idx;
        stk_wdata    = fv_val - LW'(1);
        one_wdata    = (fv_val == LW'(2));
        push.count   = 2'd0;
        push.r0      = mk(rst_pkg::EV_SIMPLE, 8'd0, 64'd0, level_reg, 1'b0, rst_pkg::ERR_NONE);
        push.r1      = push.r0;

        if (go)
        begin
            if (action)
            begin
                phase_next   = rst_pkg::PH_PREFIX;
                purpose_next = rst_pkg::LP_SIMPLE;
                held_next    = 1'b0;
                ist_next     = '0;
                bulk_next    = '0;
                level_next   = '0;
                halted_next  = 1'b0;
            end
            else if (!halted_reg)
            begin
                case (phase_reg)
                    rst_pkg::PH_PREFIX:
                    begin
                        phase_next = rst_pkg::PH_LINE;
                        held_next  = 1'b0;
                        ist_next   = '0;
                        case (stream_byte)
                            rst_pkg::CH_PLUS:
                            begin
                                purpose_next = rst_pkg::LP_SIMPLE;
                                push.count   = 2'd1;
                            end
                            rst_pkg::CH_MINUS:
                            begin
                                purpose_next = rst_pkg::LP_ERROR;
                                push.count   = 2'd1;
                                push.r0.event_res = rst_pkg::EV_ERRSTR;
                            end
                            rst_pkg::CH_COLON: purpose_next = rst_pkg::LP_INT;
                            rst_pkg::CH_DOLAR: purpose_next = rst_pkg::LP_BULKLEN;
                            rst_pkg::CH_STAR:  purpose_next = rst_pkg::LP_COUNT;
                            default:
                            begin
                                phase_next  = phase_reg;
                                held_next   = held_reg;
                                ist_next    = ist_reg;
                                halted_next = 1'b1;
                                push.count  = 2'd1;
                                push.r0     = mk(rst_pkg::EV_FAULT, 8'd0, 64'd0, level_reg,
                                                 1'b0, rst_pkg::ERR_PREFIX);
                            end
                        endcase
                    end
                    rst_pkg::PH_LINE:
                    begin
                        if (held_reg && stream_byte == rst_pkg::CH_LF)
                        begin
                            held_next  = 1'b0;
                            phase_next = rst_pkg::PH_PREFIX;
                            push.count = 2'd1;
                            if (is_str)
                            begin
                                level_next = fv_level;
                                stk_we     = fv_found;
                                push.r0    = mk(rst_pkg::EV_END, 8'd0, 64'd0, level_reg,
                                                !fv_found, rst_pkg::ERR_NONE);
                            end
                            else if (ist_reg.inval || !ist_reg.digit)
                            begin
                                halted_next = 1'b1;
                                push.r0 = mk(rst_pkg::EV_FAULT, 8'd0, 64'd0, level_reg,
                                             1'b0, rst_pkg::ERR_INT);
                            end
                            else if (purpose_reg == rst_pkg::LP_BULKLEN)
                            begin
                                if (ist_reg.neg && ist_reg.accum == 64'd1)
                                begin
                                    level_next = fv_level;
                                    stk_we     = fv_found;
                                    push.r0    = mk(rst_pkg::EV_NULL, 8'd0, 64'd0, level_reg,
                                                    !fv_found, rst_pkg::ERR_NONE);
                                end
                                else if (ist_reg.neg && ist_reg.accum > 64'd1)
                                begin
                                    halted_next = 1'b1;
                                    push.r0 = mk(rst_pkg::EV_FAULT, 8'd0, 64'd0, level_reg,
                                                 1'b0, rst_pkg::ERR_LEN);
                                end
                                else if (too_big)
                                begin
                                    halted_next = 1'b1;
                                    push.r0 = mk(rst_pkg::EV_FAULT, 8'd0, 64'd0, level_reg,
                                                 1'b0, rst_pkg::ERR_BIG);
                                end
                                else
                                begin
                                    bulk_next  = ist_reg.accum[LW-1:0];
                                    phase_next = (ist_reg.accum == 64'd0) ?
                                                 rst_pkg::PH_BULK_CR : rst_pkg::PH_BULK;
                                    push.r0 = mk(rst_pkg::EV_BULK, 8'd0, ist_reg.accum,
                                                 level_reg, 1'b0, rst_pkg::ERR_NONE);
                                end
                            end
                            else if (purpose_reg == rst_pkg::LP_COUNT)
                            begin
                                if (ist_reg.neg && ist_reg.accum != 64'd0)
                                begin
                                    halted_next = 1'b1;
                                    push.r0 = mk(rst_pkg::EV_FAULT, 8'd0, 64'd0, level_reg,
                                                 1'b0, rst_pkg::ERR_COUNT);
                                end
                                else if (too_big)
                                begin
                                    halted_next = 1'b1;
                                    push.r0 = mk(rst_pkg::EV_FAULT, 8'd0, 64'd0, level_reg,
                                                 1'b0, rst_pkg::ERR_BIG);
                                end
                                else if (ist_reg.accum == 64'd0)
                                begin
                                    level_next = fv_level;
                                    stk_we     = fv_found;
                                    push.r0    = mk(rst_pkg::EV_ARRAY, 8'd0, 64'd0, level_reg,
                                                    !fv_found, rst_pkg::ERR_NONE);
                                end
                                else if (level_reg >= DW'(MD))
                                begin
                                    halted_next = 1'b1;
                                    push.r0 = mk(rst_pkg::EV_FAULT, 8'd0, 64'd0, level_reg,
                                                 1'b0, rst_pkg::ERR_DEEP);
                                end
                                else
                                begin
                                    stk_we     = 1'b1;
                                    stk_idx    = level_reg[IW-1:0];
                                    stk_wdata  = ist_reg.accum[LW-1:0];
                                    one_wdata  = (ist_reg.accum == 64'd1);
                                    level_next = level_reg + DW'(1);
                                    push.r0    = mk(rst_pkg::EV_ARRAY, 8'd0, ist_reg.accum,
                                                    level_reg, 1'b0, rst_pkg::ERR_NONE);
                                end
                            end
                            else
                            begin
                                level_next = fv_level;
                                stk_we     = fv_found;
                                push.r0    = mk(rst_pkg::EV_INT, 8'd0, int_val, level_reg,
                                                !fv_found, rst_pkg::ERR_NONE);
                            end
                        end
                        else if (held_reg)
                        begin
                            // Held CR was line content; the new byte follows it.
                            push.r0 = mk(rst_pkg::EV_PAYLOAD, rst_pkg::CH_CR, 64'd0, level_reg,
                                         1'b0, rst_pkg::ERR_NONE);
                            push.r1 = mk(rst_pkg::EV_PAYLOAD, stream_byte, 64'd0, level_reg,
                                         1'b0, rst_pkg::ERR_NONE);
                            if (stream_byte == rst_pkg::CH_CR)
                            begin
                                push.count = is_str ? 2'd1 : 2'd0;
                                ist_next   = is_str ? ist_reg : ist_cr;
                            end
                            else
                            begin
                                held_next  = 1'b0;
                                push.count = is_str ? 2'd2 : 2'd0;
                                ist_next   = is_str ? ist_reg : int_char(ist_cr, stream_byte);
                            end
                        end
                        else if (stream_byte == rst_pkg::CH_CR)
                        begin
                            held_next = 1'b1;
                        end
                        else if (is_str)
                        begin
                            push.count = 2'd1;
                            push.r0 = mk(rst_pkg::EV_PAYLOAD, stream_byte, 64'd0, level_reg,
                                         1'b0, rst_pkg::ERR_NONE);
                        end
                        else
                        begin
                            ist_next = int_char(ist_reg, stream_byte);
                        end
                    end
                    rst_pkg::PH_BULK:
                    begin
                        push.count = 2'd1;
                        push.r0 = mk(rst_pkg::EV_PAYLOAD, stream_byte, 64'd0, level_reg,
                                     1'b0, rst_pkg::ERR_NONE);
                        bulk_next = (bulk_reg == '0) ? '0 : bulk_reg - LW'(1);
                        if (bulk_reg <= LW'(1))
                        begin
                            phase_next = rst_pkg::PH_BULK_CR;
                        end
                    end
                    rst_pkg::PH_BULK_CR:
                    begin
                        if (stream_byte != rst_pkg::CH_CR)
                        begin
                            halted_next = 1'b1;
                            push.count  = 2'd1;
                            push.r0 = mk(rst_pkg::EV_FAULT, 8'd0, 64'd0, level_reg,
                                         1'b0, rst_pkg::ERR_BULK);
                        end
                        else
                        begin
                            phase_next = rst_pkg::PH_BULK_LF;
                        end
                    end
                    rst_pkg::PH_BULK_LF:
                    begin
                        push.count = 2'd1;
                        if (stream_byte != rst_pkg::CH_LF)
                        begin
                            halted_next = 1'b1;
                            push.r0 = mk(rst_pkg::EV_FAULT, 8'd0, 64'd0, level_reg,
                                         1'b0, rst_pkg::ERR_BULK);
                        end
                        else
                        begin
                            phase_next = rst_pkg::PH_PREFIX;
                            level_next = fv_level;
                            stk_we     = fv_found;
                            push.r0    = mk(rst_pkg::EV_END, 8'd0, 64'd0, level_reg,
                                            !fv_found, rst_pkg::ERR_NONE);
                        end
                    end
                    default:
                    begin
                        phase_next = rst_pkg::PH_PREFIX;
                    end
                endcase
            end
        end

        if (push.count == 2'd1)
        begin
            push.r0.last = 1'b1;
        end
        else if (push.count == 2'd2)
        begin
            push.r1.last = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= rst_pkg::PH_PREFIX;
            purpose_reg <= rst_pkg::LP_SIMPLE;
            held_reg    <= 1'b0;
            ist_reg     <= '0;
            bulk_reg    <= '0;
            level_reg   <= '0;
            halted_reg  <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            purpose_reg <= purpose_next;
            held_reg    <= held_next;
            ist_reg     <= ist_next;
            bulk_reg    <= bulk_next;
            level_reg   <= level_next;
            halted_reg  <= halted_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stack_reg[stk_idx] <= stk_wdata;
            one_reg[stk_idx]   <= one_wdata;
        end
    end

endmodule

FILE: src/rst_queue.sv
module rst_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  rst_pkg::push_t     push,
    input  logic               pop,
    output logic               room,
    output logic               head_valid,
    output rst_pkg::result_t   head
);

    localparam int PW = rst_pkg::Q_PTR_W;
    localparam int CW = rst_pkg::Q_CNT_W;

    rst_pkg::result_t mem_reg [rst_pkg::Q_DEPTH];
    logic [PW-1:0]    wr_reg, wr_next;
    logic [PW-1:0]    rd_reg, rd_next;
    logic [CW-1:0]    cnt_reg, cnt_next;

    assign room       = cnt_reg <= CW'(rst_pkg::Q_DEPTH - 2);
    assign head_valid = cnt_reg != '0;
    assign head       = mem_reg[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg + PW'(push.count);
        rd_next  = rd_reg + PW'(pop);
        cnt_next = cnt_reg + CW'(push.count) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem_reg[wr_reg] <= push.r0;
        end
        if (push.count == 2'd2)
        begin
            mem_reg[wr_reg + PW'(1)] <= push.r1;
        end
    end

endmodule
